FILE: src/rtpfu_pkg.sv
// ----------------------------------------------------------------------------
// rtpfu_pkg
// Shared types and constants of the RTP H.264 FU-A packetizer.
// ----------------------------------------------------------------------------
`default_nettype none

package rtpfu_pkg;

  // Input commands
  localparam logic [1:0] CMD_VIDEO = 2'd0;
  localparam logic [1:0] CMD_AUDIO = 2'd1;
  localparam logic [1:0] CMD_DUMMY = 2'd2;
  localparam logic [1:0] CMD_RSVD  = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] REG_FIRST_HDR  = 3'd0;
  localparam logic [2:0] REG_MARKED     = 3'd1;
  localparam logic [2:0] REG_UNMARKED   = 3'd2;
  localparam logic [2:0] REG_AUDIO_TYPE = 3'd3;
  localparam logic [2:0] REG_SSRC       = 3'd4;
  localparam logic [2:0] REG_MAX_PKT    = 3'd5;
  localparam logic [2:0] REG_START_SEQ  = 3'd6;

  // Packet constants
  localparam logic [15:0] HDR_LEN        = 16'd12;
  localparam logic [15:0] MIN_PKT        = 16'd16;
  localparam logic [7:0]  NAL_TYPE_MASK  = 8'h1f;
  localparam logic [7:0]  NRI_MASK       = 8'he0;
  localparam logic [7:0]  FU_A_TYPE      = 8'h1c;
  localparam logic [7:0]  FU_START_BIT   = 8'h80;
  localparam logic [7:0]  FU_END_BIT     = 8'h40;

  // Byte positions within one job as serialised by the back end
  localparam logic [3:0] POS_HDR_FIRST = 4'd0;
  localparam logic [3:0] POS_HDR_LAST  = 4'd11;
  localparam logic [3:0] POS_FU_IND    = 4'd12;
  localparam logic [3:0] POS_FU_HDR    = 4'd13;
  localparam logic [3:0] POS_DATA      = 4'd14;

  // Configuration registers as seen by the datapath
  typedef struct packed {
    logic [7:0]  first_hdr;
    logic [7:0]  marked;
    logic [7:0]  unmarked;
    logic [7:0]  audio_type;
    logic [31:0] ssrc;
    logic [15:0] max_pkt;
  } cfg_t;

  // One job: the output bytes caused by one input item
  typedef struct packed {
    logic        hdr_en;
    logic        fu_en;
    logic        data_en;
    logic        alone;      // header is the whole packet and frame
    logic [7:0]  second;
    logic [15:0] seq;
    logic [31:0] ts;
    logic [7:0]  fu_ind;
    logic [7:0]  fu_hdr;
    logic [7:0]  data;
    logic        plast;
    logic        flast;
  } job_t;

endpackage

`default_nettype wire

FILE: src/rtpfu_front.sv
// ----------------------------------------------------------------------------
// rtpfu_front
// Tracks frame, fragment and sequence state and turns each item into a job.
// ----------------------------------------------------------------------------
`default_nettype none

module rtpfu_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire rtpfu_pkg::cfg_t  cfg_i,
  input  wire logic             seq_load_i,
  input  wire logic [15:0]      seq_value_i,
  input  wire logic             accept_i,
  input  wire logic [1:0]       cmd_i,
  input  wire logic [7:0]       data_byte_i,
  input  wire logic [23:0]      frame_bytes_i,
  input  wire logic [31:0]      timestamp_i,
  output rtpfu_pkg::job_t       job_o,
  output logic                  push_o
);

  logic [23:0] pos_q, pos_d, rem_q, rem_d;
  logic [15:0] seq_q, seq_d, fill_q, fill_d;
  logic [7:0]  nal_q, nal_d;
  logic        frag_q, frag_d, audio_q, audio_d;
  logic [31:0] ts_q, ts_d;

  logic [23:0] pos_e, rem_e;
  logic [15:0] fill_e, fill_inc, clamp, space, space_m2;
  logic        frag_e, audio_e, run, last, fin, pkt_end, emit;
  logic [31:0] ts_e;
  rtpfu_pkg::job_t job;

  // Payload room per packet, size floored at the minimum packet
  assign clamp    = (cfg_i.max_pkt < rtpfu_pkg::MIN_PKT) ? rtpfu_pkg::MIN_PKT : cfg_i.max_pkt;
  assign space    = clamp - rtpfu_pkg::HDR_LEN;
  assign space_m2 = space - 16'd2;

  // Classify the item
  always_comb begin
    job      = '0;
    emit     = 1'b0;
    run      = 1'b0;
    pos_d    = pos_q;
    rem_d    = rem_q;
    fill_d   = fill_q;
    frag_d   = frag_q;
    nal_d    = nal_q;
    ts_d     = ts_q;
    audio_d  = audio_q;
    pos_e    = pos_q;
    rem_e    = rem_q;
    fill_e   = fill_q;
    frag_e   = frag_q;
    audio_e  = audio_q;
    ts_e     = ts_q;
    last     = 1'b0;
    fin      = 1'b0;
    pkt_end  = 1'b0;
    fill_inc = '0;

    // frame start or a stand-alone packet
    if (rem_q == '0) begin
      unique case (cmd_i)
        rtpfu_pkg::CMD_DUMMY: begin
          job.hdr_en = 1'b1;
          job.alone  = 1'b1;
          job.second = cfg_i.unmarked;
          job.ts     = '0;
        end
        rtpfu_pkg::CMD_RSVD: ;
        default: begin
          if (frame_bytes_i == '0) begin
            if (cmd_i == rtpfu_pkg::CMD_AUDIO) begin
              job.hdr_en = 1'b1;
              job.alone  = 1'b1;
              job.second = cfg_i.audio_type;
              job.ts     = timestamp_i;
            end
          end else begin
            run     = 1'b1;
            audio_e = (cmd_i == rtpfu_pkg::CMD_AUDIO);
            ts_e    = timestamp_i;
            rem_e   = frame_bytes_i;
            pos_e   = '0;
            frag_e  = 1'b0;
            fill_e  = '0;
          end
        end
      endcase
    end else begin
      run = 1'b1;
    end

    // byte of an open frame
    if (run) begin
      last    = (rem_e == 24'd1);
      pos_d   = pos_e + 24'd1;
      rem_d   = rem_e - 24'd1;
      audio_d = audio_e;
      ts_d    = ts_e;
      frag_d  = frag_e;
      fill_d  = fill_e;
      job.ts  = ts_e;
      if (audio_e) begin
        job.hdr_en  = (pos_e == '0);
        job.second  = cfg_i.audio_type;
        job.data_en = 1'b1;
        job.data    = data_byte_i;
        job.plast   = last;
        job.flast   = last;
      end else if (pos_e < 24'd4) begin
        // start code, dropped
      end else if (pos_e == 24'd4) begin
        nal_d      = data_byte_i;
        job.hdr_en = 1'b1;
        if (rem_e <= {8'd0, space}) begin
          frag_d      = 1'b0;
          job.second  = cfg_i.marked;
          job.data_en = 1'b1;
          job.data    = data_byte_i;
          job.plast   = last;
          job.flast   = last;
        end else begin
          frag_d     = 1'b1;
          job.second = cfg_i.unmarked;
          job.fu_en  = 1'b1;
          job.fu_ind = (data_byte_i & rtpfu_pkg::NRI_MASK) | rtpfu_pkg::FU_A_TYPE;
          job.fu_hdr = rtpfu_pkg::FU_START_BIT | (data_byte_i & rtpfu_pkg::NAL_TYPE_MASK);
          fill_d     = 16'd2;
        end
      end else if (!frag_e) begin
        job.data_en = 1'b1;
        job.data    = data_byte_i;
        job.plast   = last;
        job.flast   = last;
      end else begin
        // fragment payload, opening a new fragment if none is open
        fill_inc = fill_e + 16'd1;
        if (fill_e == '0) begin
          fin        = (rem_e <= {8'd0, space_m2});
          job.hdr_en = 1'b1;
          job.second = fin ? cfg_i.marked : cfg_i.unmarked;
          job.fu_en  = 1'b1;
          job.fu_ind = (nal_q & rtpfu_pkg::NRI_MASK) | rtpfu_pkg::FU_A_TYPE;
          job.fu_hdr = (fin ? rtpfu_pkg::FU_END_BIT : 8'd0)
                     | (nal_q & rtpfu_pkg::NAL_TYPE_MASK);
          fill_inc   = 16'd3;
        end
        pkt_end     = last || (fill_inc >= space);
        job.data_en = 1'b1;
        job.data    = data_byte_i;
        job.plast   = pkt_end;
        job.flast   = last;
        fill_d      = pkt_end ? 16'd0 : fill_inc;
      end
    end

    job.seq = seq_q;
    seq_d   = job.hdr_en ? (seq_q + 16'd1) : seq_q;
    emit    = job.hdr_en | job.fu_en | job.data_en;
  end

  assign job_o  = job;
  assign push_o = accept_i & emit;

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      rem_q   <= '0;
      seq_q   <= '0;
      nal_q   <= '0;
      fill_q  <= '0;
      frag_q  <= 1'b0;
      ts_q    <= '0;
      audio_q <= 1'b0;
    end else if (seq_load_i) begin
      seq_q <= seq_value_i;
    end else if (accept_i) begin
      pos_q   <= pos_d;
      rem_q   <= rem_d;
      seq_q   <= seq_d;
      nal_q   <= nal_d;
      fill_q  <= fill_d;
      frag_q  <= frag_d;
      ts_q    <= ts_d;
      audio_q <= audio_d;
    end
  end

endmodule

`default_nettype wire

FILE: src/rtpfu_queue.sv
// ----------------------------------------------------------------------------
// rtpfu_queue
// Small first-in first-out queue of jobs between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module rtpfu_queue #(
  parameter int unsigned Depth = 4
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire rtpfu_pkg::job_t job_i,
  output logic                 full_o,
  output logic                 valid_o,
  input  wire logic            pop_i,
  output rtpfu_pkg::job_t      job_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrMax = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntMax = CntW'(Depth);

  rtpfu_pkg::job_t     mem_q [Depth];
  logic [PtrW-1:0]     wr_q, rd_q;
  logic [CntW-1:0]     cnt_q;
  logic                do_push, do_pop;

  assign full_o  = (cnt_q == CntMax);
  assign valid_o = (cnt_q != '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;
  assign job_o   = mem_q[rd_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrMax) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrMax) ? '0 : rd_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/rtpfu_back.sv
// ----------------------------------------------------------------------------
// rtpfu_back
// Serialises jobs to packet bytes in an output stage, one per clock if ready.
// ----------------------------------------------------------------------------
`default_nettype none

module rtpfu_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire rtpfu_pkg::cfg_t cfg_i,
  input  wire logic            job_valid_i,
  input  wire rtpfu_pkg::job_t job_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic [7:0]           out_byte_o,
  output logic                 out_plast_o,
  output logic                 out_flast_o
);

  rtpfu_pkg::job_t cur_q;
  logic            cur_valid_q;
  logic [3:0]      idx_q, idx_next, idx_start;
  logic            out_valid_q, plast_q, flast_q;
  logic [7:0]      byte_q;
  logic            adv, final_byte, load;
  logic [7:0]      hdr_b [12];
  logic [7:0]      byte_sel;
  logic            plast_sel, flast_sel;

  assign adv = cur_valid_q & (~out_valid_q | out_ready_i);

  // End of the current job
  assign final_byte = (idx_q == rtpfu_pkg::POS_DATA)
                    | ((idx_q == rtpfu_pkg::POS_FU_HDR) & ~cur_q.data_en)
                    | ((idx_q == rtpfu_pkg::POS_HDR_LAST) & ~cur_q.fu_en & ~cur_q.data_en);

  assign load  = job_valid_i & (~cur_valid_q | (adv & final_byte));
  assign pop_o = load;

  // First position of an incoming job
  assign idx_start = job_i.hdr_en ? rtpfu_pkg::POS_HDR_FIRST :
                     job_i.fu_en  ? rtpfu_pkg::POS_FU_IND : rtpfu_pkg::POS_DATA;

  // Step to the next position, skipping absent sections
  always_comb begin
    if (idx_q == rtpfu_pkg::POS_HDR_LAST) begin
      idx_next = cur_q.fu_en ? rtpfu_pkg::POS_FU_IND : rtpfu_pkg::POS_DATA;
    end else if (idx_q == rtpfu_pkg::POS_FU_HDR) begin
      idx_next = rtpfu_pkg::POS_DATA;
    end else begin
      idx_next = idx_q + 4'd1;
    end
  end

  // Header bytes, big-endian fields
  always_comb begin
    hdr_b[0]  = cfg_i.first_hdr;
    hdr_b[1]  = cur_q.second;
    hdr_b[2]  = cur_q.seq[15:8];
    hdr_b[3]  = cur_q.seq[7:0];
    hdr_b[4]  = cur_q.ts[31:24];
    hdr_b[5]  = cur_q.ts[23:16];
    hdr_b[6]  = cur_q.ts[15:8];
    hdr_b[7]  = cur_q.ts[7:0];
    hdr_b[8]  = cfg_i.ssrc[31:24];
    hdr_b[9]  = cfg_i.ssrc[23:16];
    hdr_b[10] = cfg_i.ssrc[15:8];
    hdr_b[11] = cfg_i.ssrc[7:0];
  end

  // Byte and flag selection
  always_comb begin
    plast_sel = 1'b0;
    flast_sel = 1'b0;
    if (idx_q == rtpfu_pkg::POS_FU_IND) begin
      byte_sel = cur_q.fu_ind;
    end else if (idx_q == rtpfu_pkg::POS_FU_HDR) begin
      byte_sel = cur_q.fu_hdr;
    end else if (idx_q == rtpfu_pkg::POS_DATA) begin
      byte_sel  = cur_q.data;
      plast_sel = cur_q.plast;
      flast_sel = cur_q.flast;
    end else if (idx_q <= rtpfu_pkg::POS_HDR_LAST) begin
      byte_sel = hdr_b[idx_q];
      if (idx_q == rtpfu_pkg::POS_HDR_LAST) begin
        plast_sel = cur_q.alone;
        flast_sel = cur_q.alone;
      end
    end else begin
      byte_sel = cur_q.data;
    end
  end

  // Job holding register
  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q <= job_i;
    end
  end

  // Position and valid control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= '0;
    end else if (load) begin
      cur_valid_q <= 1'b1;
      idx_q       <= idx_start;
    end else if (adv) begin
      if (final_byte) begin
        cur_valid_q <= 1'b0;
      end else begin
        idx_q <= idx_next;
      end
    end
  end

  // Output stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      byte_q  <= byte_sel;
      plast_q <= plast_sel;
      flast_q <= flast_sel;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = byte_q;
  assign out_plast_o = plast_q;
  assign out_flast_o = flast_q;

endmodule

`default_nettype wire

FILE: src/rtp_h264_fu_a_packetizer_unit.sv
// ----------------------------------------------------------------------------
// rtp_h264_fu_a_packetizer_unit
// RTP packetizer for H.264 (single NAL / FU-A), PCMA audio and dummy headers.
// ----------------------------------------------------------------------------
// Frame bytes enter one item per clock while the queue is not full; the front
// end tracks frame and fragment state and hands each item's work as a job to
// a queue of QueueDepth entries, and the back end writes it out as packet
// bytes at one byte per clock, unless the receiver stalls, through a
// registered output. An item that continues a packet yields one byte; one
// that opens a packet yields the 12-byte header and its byte (audio or single
// NAL), the header, FU indicator and FU header (first fragment) or all four
// (later fragments); a dummy or an empty audio frame yields the header alone,
// a start code byte none. Configuration is written through cfg_we_i/
// cfg_addr_i/cfg_wdata_i; writing start_sequence reloads the sequence counter.
`default_nettype none

module rtp_h264_fu_a_packetizer_unit #(
  parameter int unsigned QueueDepth = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_addr_i,
  input  wire logic [31:0] cfg_wdata_i,
  // input stream
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [63:0] s_axis_tdata_i,   // data_byte[7:0], frame_bytes[31:8],
                                             // timestamp[63:32]
  input  wire logic [1:0]  s_axis_tuser_i,   // cmd[1:0]
  // output stream
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [7:0]       m_axis_tdata_o,   // out_byte[7:0]
  output logic             m_axis_tlast_o,   // packet_last
  output logic             m_axis_tuser_o    // frame_last
);

  rtpfu_pkg::cfg_t cfg_q;
  rtpfu_pkg::job_t job_in, job_out;
  logic            accept, push, full, q_valid, pop, seq_load;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.first_hdr  <= 8'd128;
      cfg_q.marked     <= 8'd224;
      cfg_q.unmarked   <= 8'd96;
      cfg_q.audio_type <= 8'd8;
      cfg_q.ssrc       <= 32'd8472857;
      cfg_q.max_pkt    <= 16'd1400;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        rtpfu_pkg::REG_FIRST_HDR:  cfg_q.first_hdr  <= cfg_wdata_i[7:0];
        rtpfu_pkg::REG_MARKED:     cfg_q.marked     <= cfg_wdata_i[7:0];
        rtpfu_pkg::REG_UNMARKED:   cfg_q.unmarked   <= cfg_wdata_i[7:0];
        rtpfu_pkg::REG_AUDIO_TYPE: cfg_q.audio_type <= cfg_wdata_i[7:0];
        rtpfu_pkg::REG_SSRC:       cfg_q.ssrc       <= cfg_wdata_i;
        rtpfu_pkg::REG_MAX_PKT:    cfg_q.max_pkt    <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  assign seq_load        = cfg_we_i & (cfg_addr_i == rtpfu_pkg::REG_START_SEQ);
  assign s_axis_tready_o = ~full;
  assign accept          = s_axis_tvalid_i & ~full;

  rtpfu_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .seq_load_i   (seq_load),
    .seq_value_i  (cfg_wdata_i[15:0]),
    .accept_i     (accept),
    .cmd_i        (s_axis_tuser_i),
    .data_byte_i  (s_axis_tdata_i[7:0]),
    .frame_bytes_i(s_axis_tdata_i[31:8]),
    .timestamp_i  (s_axis_tdata_i[63:32]),
    .job_o        (job_in),
    .push_o       (push)
  );

  rtpfu_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job_in),
    .full_o (full),
    .valid_o(q_valid),
    .pop_i  (pop),
    .job_o  (job_out)
  );

  rtpfu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (q_valid),
    .job_i       (job_out),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_byte_o  (m_axis_tdata_o),
    .out_plast_o (m_axis_tlast_o),
    .out_flast_o (m_axis_tuser_o)
  );

endmodule

`default_nettype wire

FILE: dv/rtp_h264_fu_a_packetizer_unit_tb.sv
// ----------------------------------------------------------------------------
// rtp_h264_fu_a_packetizer_unit_tb
// Self-checking bench for the RTP H.264 FU-A packetizer: a short table of
// directed items and register writes, then randomised frames (video, audio,
// dummies, noise) over several register settings. Every output byte is
// compared with a packet predictor kept in step with the accepted items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rtp_h264_fu_a_packetizer_unit_tb;

  localparam int unsigned Settle       = 100;     // cycles for the job queue to empty
  localparam int unsigned CycleLimit   = 600000;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned PhaseItems   = 80;
  localparam int unsigned NumPhases    = 6;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  db;
    logic [23:0] fb;
    logic [31:0] ts;
  } pkt_item_t;

  typedef struct packed {
    logic [7:0] b;
    logic       plast;
    logic       flast;
  } pkt_byte_t;

  // directed row: an item, or a register write when is_cfg is set
  typedef struct packed {
    logic        is_cfg;
    logic [2:0]  addr;
    logic [31:0] val;
    pkt_item_t   item;
    logic        typed;
    logic [4:0]  n_bytes;
    logic [7:0]  tail;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [2:0]  cfg_addr;
  logic [31:0] cfg_wdata;
  logic        s_valid;
  logic [63:0] s_data;
  logic [1:0]  s_user;
  logic        m_ready;
  wire         s_ready;
  wire         m_valid;
  wire  [7:0]  m_data;
  wire         m_last;
  wire         m_user;

  rtp_h264_fu_a_packetizer_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tlast_o  (m_last),
    .m_axis_tuser_o  (m_user)
  );

  // Predictor state and its copy of the registers
  logic [7:0]  r_first, r_marked, r_unmarked, r_audio;
  logic [31:0] r_ssrc;
  logic [15:0] r_max_pkt;
  logic [23:0] frame_pos, frame_left;
  logic [15:0] seq_count;
  logic [7:0]  nal_hdr;
  logic [15:0] frag_fill;
  logic        in_fu;
  logic [31:0] frame_ts;
  logic        frame_audio;

  pkt_byte_t   expected_bytes[$];
  dir_row_t    dir_rows[$];
  int unsigned bytes_predicted;
  logic [7:0]  last_predicted;
  int unsigned mismatches;
  int unsigned bytes_seen;
  int unsigned phase_sent;
  bit          idle_en;
  bit          hold_req;
  pkt_byte_t   mon_exp;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("FAIL rtp_h264_fu_a_packetizer_unit");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s at byte %0d: got %0h want %0h", what, bytes_seen, got, want);
    mismatches++;
  endtask

  // ---------------------------------------------------------------- predictor
  function automatic void reset_model();
    r_first     = 8'd128;
    r_marked    = 8'd224;
    r_unmarked  = 8'd96;
    r_audio     = 8'd8;
    r_ssrc      = 32'd8472857;
    r_max_pkt   = 16'd1400;
    seq_count   = '0;
    frame_pos   = '0;
    frame_left  = '0;
    nal_hdr     = '0;
    frag_fill   = '0;
    in_fu       = 1'b0;
    frame_ts    = '0;
    frame_audio = 1'b0;
  endfunction

  function automatic void model_reg(input logic [2:0] addr, input logic [31:0] val);
    case (addr)
      rtpfu_pkg::REG_FIRST_HDR:  r_first    = val[7:0];
      rtpfu_pkg::REG_MARKED:     r_marked   = val[7:0];
      rtpfu_pkg::REG_UNMARKED:   r_unmarked = val[7:0];
      rtpfu_pkg::REG_AUDIO_TYPE: r_audio    = val[7:0];
      rtpfu_pkg::REG_SSRC:       r_ssrc     = val;
      rtpfu_pkg::REG_MAX_PKT:    r_max_pkt  = val[15:0];
      rtpfu_pkg::REG_START_SEQ:  seq_count  = val[15:0];
      default: ;
    endcase
  endfunction

  function automatic void push_byte(input logic [7:0] b, input logic pl, input logic fl);
    expected_bytes.push_back('{b: b, plast: pl, flast: fl});
    bytes_predicted++;
    last_predicted = b;
  endfunction

  // 12-byte header, big-endian fields; alone flags its last byte
  function automatic void push_header(input logic [7:0] second, input logic [31:0] ts,
                                      input logic alone);
    logic [15:0] s;
    s = seq_count;
    seq_count = seq_count + 16'd1;
    push_byte(r_first, 1'b0, 1'b0);
    push_byte(second, 1'b0, 1'b0);
    push_byte(s[15:8], 1'b0, 1'b0);
    push_byte(s[7:0], 1'b0, 1'b0);
    push_byte(ts[31:24], 1'b0, 1'b0);
    push_byte(ts[23:16], 1'b0, 1'b0);
    push_byte(ts[15:8], 1'b0, 1'b0);
    push_byte(ts[7:0], 1'b0, 1'b0);
    push_byte(r_ssrc[31:24], 1'b0, 1'b0);
    push_byte(r_ssrc[23:16], 1'b0, 1'b0);
    push_byte(r_ssrc[15:8], 1'b0, 1'b0);
    push_byte(r_ssrc[7:0], alone, alone);
  endfunction

  function automatic void predict_bytes(input pkt_item_t it);
    logic [23:0] pos, left;
    logic        is_last, fin, closes;
    int          space;
    space = ((r_max_pkt < rtpfu_pkg::MIN_PKT) ? int'(rtpfu_pkg::MIN_PKT)
                                              : int'(r_max_pkt)) - int'(rtpfu_pkg::HDR_LEN);
    // frame start: command, length and timestamp sampled here only
    if (frame_left == '0) begin
      if (it.cmd == rtpfu_pkg::CMD_DUMMY) begin
        push_header(r_unmarked, 32'd0, 1'b1);
        return;
      end
      if (it.cmd == rtpfu_pkg::CMD_RSVD) return;
      if (it.fb == '0) begin
        if (it.cmd == rtpfu_pkg::CMD_AUDIO) push_header(r_audio, it.ts, 1'b1);
        return;
      end
      frame_audio = (it.cmd == rtpfu_pkg::CMD_AUDIO);
      frame_ts    = it.ts;
      frame_left  = it.fb;
      frame_pos   = '0;
      in_fu       = 1'b0;
      frag_fill   = '0;
    end
    pos        = frame_pos;
    left       = frame_left;
    is_last    = (left == 24'd1);
    frame_pos  = pos + 24'd1;
    frame_left = left - 24'd1;
    if (frame_audio) begin
      if (pos == '0) push_header(r_audio, frame_ts, 1'b0);
      push_byte(it.db, is_last, is_last);
      return;
    end
    // start code absorbed
    if (pos < 24'd4) return;
    // NAL header decides single packet or FU-A
    if (pos == 24'd4) begin
      nal_hdr = it.db;
      if (int'(left) <= space) begin
        in_fu = 1'b0;
        push_header(r_marked, frame_ts, 1'b0);
        push_byte(it.db, is_last, is_last);
      end else begin
        in_fu = 1'b1;
        push_header(r_unmarked, frame_ts, 1'b0);
        push_byte((it.db & rtpfu_pkg::NRI_MASK) | rtpfu_pkg::FU_A_TYPE, 1'b0, 1'b0);
        push_byte(rtpfu_pkg::FU_START_BIT | (it.db & rtpfu_pkg::NAL_TYPE_MASK),
                  1'b0, 1'b0);
        frag_fill = 16'd2;
      end
      return;
    end
    if (!in_fu) begin
      push_byte(it.db, is_last, is_last);
      return;
    end
    // open a later fragment
    if (frag_fill == '0) begin
      fin = (int'(left) <= space - 2);
      push_header(fin ? r_marked : r_unmarked, frame_ts, 1'b0);
      push_byte((nal_hdr & rtpfu_pkg::NRI_MASK) | rtpfu_pkg::FU_A_TYPE, 1'b0, 1'b0);
      push_byte((fin ? rtpfu_pkg::FU_END_BIT : 8'h00)
                | (nal_hdr & rtpfu_pkg::NAL_TYPE_MASK), 1'b0, 1'b0);
      frag_fill = 16'd2;
    end
    frag_fill = frag_fill + 16'd1;
    closes = is_last || (int'(frag_fill) >= space);
    push_byte(it.db, closes, is_last);
    if (closes) frag_fill = '0;
  endfunction

  // ---------------------------------------------------------------- drivers
  // Offer one item, with an optional gap first; returns at the accepting edge
  task automatic send_item(input pkt_item_t it);
    if (idle_en && ($urandom_range(0, 3) == 0)) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {it.ts, it.fb, it.db};
    s_user  <= it.cmd;
    do @(posedge clk_i); while (!s_ready);
    predict_bytes(it);
    phase_sent++;
  endtask

  // Stop offering and let every expected byte and queued job drain
  task automatic quiesce();
    s_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    model_reg(addr, val);
    @(posedge clk_i);
  endtask

  // Receiver: random stalls, or one long hold-off on request
  initial begin
    m_ready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        m_ready <= 1'b1;
      end else if (idle_en && ($urandom_range(0, 5) == 0)) begin
        m_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
        m_ready <= 1'b1;
      end
    end
  end

  // Output check against the oldest expected byte
  always @(posedge clk_i) begin
    if (rst_ni && m_valid && m_ready) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch("unexpected byte", {24'd0, m_data}, 32'd0);
      end else begin
        mon_exp = expected_bytes.pop_front();
        if (m_data !== mon_exp.b) report_mismatch("out_byte", {24'd0, m_data}, {24'd0, mon_exp.b});
        if (m_last !== mon_exp.plast)
          report_mismatch("packet_last", {31'd0, m_last}, {31'd0, mon_exp.plast});
        if (m_user !== mon_exp.flast)
          report_mismatch("frame_last", {31'd0, m_user}, {31'd0, mon_exp.flast});
      end
      bytes_seen++;
    end
  end

  // ---------------------------------------------------------------- stimulus
  function automatic void add_item(input logic [1:0] cmd, input logic [7:0] db,
                                   input logic [23:0] fb, input logic [31:0] ts,
                                   input logic typed, input logic [4:0] n,
                                   input logic [7:0] tail);
    dir_row_t r;
    r = '0;
    r.item    = '{cmd: cmd, db: db, fb: fb, ts: ts};
    r.typed   = typed;
    r.n_bytes = n;
    r.tail    = tail;
    dir_rows.push_back(r);
  endfunction

  function automatic void add_cfg(input logic [2:0] addr, input logic [31:0] val);
    dir_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.addr   = addr;
    r.val    = val;
    dir_rows.push_back(r);
  endfunction

  function automatic void load_table();
    // dummy and empty audio after reset: header only, SSRC low byte last
    add_item(rtpfu_pkg::CMD_DUMMY, 8'hA5, 24'hFFFFFF, 32'hFFFFFFFF, 1'b1, 5'd12, 8'h19);
    add_item(rtpfu_pkg::CMD_RSVD,  8'h5A, 24'd7,      32'h0,        1'b1, 5'd0,  8'h00);
    add_item(rtpfu_pkg::CMD_VIDEO, 8'hFF, 24'd0,      32'h1,        1'b1, 5'd0,  8'h00);
    add_item(rtpfu_pkg::CMD_AUDIO, 8'h00, 24'd0,      32'hFFFFFFFF, 1'b1, 5'd12, 8'h19);
    // video carrying start code only
    add_item(rtpfu_pkg::CMD_VIDEO, 8'h00, 24'd4, 32'h0, 1'b1, 5'd0, 8'h00);
    add_item(rtpfu_pkg::CMD_AUDIO, 8'h00, 24'd0, 32'h0, 1'b1, 5'd0, 8'h00);
    add_item(rtpfu_pkg::CMD_DUMMY, 8'h00, 24'd0, 32'h0, 1'b1, 5'd0, 8'h00);
    add_item(rtpfu_pkg::CMD_RSVD,  8'h01, 24'd0, 32'h0, 1'b1, 5'd0, 8'h00);
    // single NAL of one byte
    add_item(rtpfu_pkg::CMD_VIDEO, 8'h00, 24'd5, 32'h12345678, 1'b1, 5'd0, 8'h00);
    add_item(rtpfu_pkg::CMD_VIDEO, 8'h00, 24'd0, 32'h0, 1'b1, 5'd0, 8'h00);
    add_item(rtpfu_pkg::CMD_VIDEO, 8'h00, 24'd0, 32'h0, 1'b1, 5'd0, 8'h00);
    add_item(rtpfu_pkg::CMD_VIDEO, 8'h01, 24'd0, 32'h0, 1'b1, 5'd0, 8'h00);
    add_item(rtpfu_pkg::CMD_VIDEO, 8'h65, 24'd0, 32'h0, 1'b1, 5'd13, 8'h65);
    // two-byte audio frame
    add_item(rtpfu_pkg::CMD_AUDIO, 8'h00, 24'd2, 32'h0, 1'b1, 5'd13, 8'h00);
    add_item(rtpfu_pkg::CMD_RSVD,  8'hFF, 24'd0, 32'h0, 1'b1, 5'd1,  8'hFF);
    // FU-A with a size below the minimum, sequence wrapping, size change mid-frame
    add_cfg(rtpfu_pkg::REG_MAX_PKT, 32'd0);
    add_cfg(rtpfu_pkg::REG_START_SEQ, 32'hFFFF);
    add_item(rtpfu_pkg::CMD_VIDEO, 8'h00, 24'd10, 32'hDEADBEEF, 1'b0, 5'd0, 8'h00);
    add_item(rtpfu_pkg::CMD_VIDEO, 8'h00, 24'd0, 32'h0, 1'b0, 5'd0, 8'h00);
    add_item(rtpfu_pkg::CMD_VIDEO, 8'h00, 24'd0, 32'h0, 1'b0, 5'd0, 8'h00);
    add_item(rtpfu_pkg::CMD_VIDEO, 8'h01, 24'd0, 32'h0, 1'b0, 5'd0, 8'h00);
    add_item(rtpfu_pkg::CMD_VIDEO, 8'hFF, 24'd0, 32'h0, 1'b0, 5'd0, 8'h00);
    add_item(rtpfu_pkg::CMD_VIDEO, 8'h00, 24'd0, 32'h0, 1'b0, 5'd0, 8'h00);
    add_item(rtpfu_pkg::CMD_VIDEO, 8'hFF, 24'd0, 32'h0, 1'b0, 5'd0, 8'h00);
    add_cfg(rtpfu_pkg::REG_MAX_PKT, 32'd17);
    add_item(rtpfu_pkg::CMD_VIDEO, 8'h5A, 24'd0, 32'h0, 1'b0, 5'd0, 8'h00);
    add_item(rtpfu_pkg::CMD_AUDIO, 8'hA5, 24'd0, 32'h0, 1'b0, 5'd0, 8'h00);
    add_item(rtpfu_pkg::CMD_DUMMY, 8'h3C, 24'd0, 32'h0, 1'b0, 5'd0, 8'h00);
  endfunction

  // One randomised frame, or a single noise item
  task automatic send_random_frame();
    int          sel;
    int          len;
    logic [1:0]  cmd;
    logic [31:0] ts;
    logic        junk_sc;
    pkt_item_t   it;
    sel     = $urandom_range(0, 99);
    ts      = $urandom;
    junk_sc = ($urandom_range(0, 7) == 0);
    if (sel < 8) begin
      cmd = rtpfu_pkg::CMD_DUMMY; len = 0;
    end else if (sel < 12) begin
      cmd = rtpfu_pkg::CMD_RSVD; len = 0;
    end else if (sel < 16) begin
      cmd = rtpfu_pkg::CMD_VIDEO; len = $urandom_range(0, 4);
    end else if (sel < 19) begin
      cmd = rtpfu_pkg::CMD_AUDIO; len = 0;
    end else if (sel < 38) begin
      cmd = rtpfu_pkg::CMD_AUDIO; len = $urandom_range(1, 24);
    end else begin
      cmd = rtpfu_pkg::CMD_VIDEO;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(49, 120) : $urandom_range(5, 48);
    end
    if (len == 0) begin
      it = '{cmd: cmd, db: 8'($urandom),
             fb: (cmd == rtpfu_pkg::CMD_DUMMY || cmd == rtpfu_pkg::CMD_RSVD)
                 ? 24'($urandom) : 24'd0,
             ts: ts};
      send_item(it);
    end else begin
      for (int k = 0; k < len; k++) begin
        it.cmd = (k == 0) ? cmd : 2'($urandom_range(0, 3));
        it.fb  = (k == 0) ? 24'(len) : 24'($urandom);
        it.ts  = (k == 0) ? ts : $urandom;
        if (cmd == rtpfu_pkg::CMD_VIDEO && k < 4 && !junk_sc) it.db = (k == 3) ? 8'h01 : 8'h00;
        else it.db = 8'($urandom);
        send_item(it);
      end
    end
  endtask

  // Register settings per phase: all low, all high, then random
  task automatic configure_phase(input int p);
    logic [15:0] mp;
    quiesce();
    case (p)
      0: begin
        write_reg(rtpfu_pkg::REG_FIRST_HDR, 32'h0);
        write_reg(rtpfu_pkg::REG_MARKED, 32'h0);
        write_reg(rtpfu_pkg::REG_UNMARKED, 32'h0);
        write_reg(rtpfu_pkg::REG_AUDIO_TYPE, 32'h0);
        write_reg(rtpfu_pkg::REG_SSRC, 32'h0);
        write_reg(rtpfu_pkg::REG_MAX_PKT, 32'h0);
        write_reg(rtpfu_pkg::REG_START_SEQ, 32'h0);
      end
      1: begin
        write_reg(rtpfu_pkg::REG_FIRST_HDR, 32'hFF);
        write_reg(rtpfu_pkg::REG_MARKED, 32'hFF);
        write_reg(rtpfu_pkg::REG_UNMARKED, 32'hFF);
        write_reg(rtpfu_pkg::REG_AUDIO_TYPE, 32'hFF);
        write_reg(rtpfu_pkg::REG_SSRC, 32'hFFFFFFFF);
        write_reg(rtpfu_pkg::REG_MAX_PKT, 32'hFFFF);
        write_reg(rtpfu_pkg::REG_START_SEQ, 32'hFFFF);
      end
      default: begin
        if (p == 2) mp = rtpfu_pkg::MIN_PKT;
        else if ($urandom_range(0, 3) == 0) mp = 16'($urandom_range(0, 15));
        else mp = 16'($urandom_range(16, 40));
        write_reg(rtpfu_pkg::REG_FIRST_HDR, {24'd0, 8'($urandom)});
        write_reg(rtpfu_pkg::REG_MARKED, {24'd0, 8'($urandom)});
        write_reg(rtpfu_pkg::REG_UNMARKED, {24'd0, 8'($urandom)});
        write_reg(rtpfu_pkg::REG_AUDIO_TYPE, {24'd0, 8'($urandom)});
        write_reg(rtpfu_pkg::REG_SSRC, $urandom);
        write_reg(rtpfu_pkg::REG_MAX_PKT, {16'd0, mp});
        write_reg(rtpfu_pkg::REG_START_SEQ, {16'd0, 16'($urandom)});
      end
    endcase
  endtask

  // ---------------------------------------------------------------- main
  initial begin
    int unsigned prior_count;
    int unsigned w;
    dir_row_t    row;
    mismatches      = 0;
    bytes_seen      = 0;
    bytes_predicted = 0;
    last_predicted  = '0;
    idle_en         = 1'b1;
    hold_req        = 1'b0;
    rst_ni    <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_addr  <= '0;
    cfg_wdata <= '0;
    s_valid   <= 1'b0;
    s_data    <= '0;
    s_user    <= '0;
    reset_model();
    load_table();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (Settle) @(posedge clk_i);

    // directed table
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.is_cfg) begin
        quiesce();
        write_reg(row.addr, row.val);
      end else begin
        prior_count = bytes_predicted;
        send_item(row.item);
        if (row.typed) begin
          if (bytes_predicted - prior_count != {27'd0, row.n_bytes})
            report_mismatch("row byte count", bytes_predicted - prior_count,
                            {27'd0, row.n_bytes});
          else if (row.n_bytes != 5'd0 && last_predicted != row.tail)
            report_mismatch("row last byte", {24'd0, last_predicted}, {24'd0, row.tail});
        end
      end
    end

    // random phases; long receiver hold-off in one, no idling in the last
    for (int p = 0; p < NumPhases; p++) begin
      configure_phase(p);
      if (p == 4) hold_req = 1'b1;
      if (p == NumPhases - 1) idle_en = 1'b0;
      phase_sent = 0;
      while (phase_sent < PhaseItems) send_random_frame();
    end

    // drain
    s_valid <= 1'b0;
    for (w = 0; w < 50000 && expected_bytes.size() != 0; w++) @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);
    if (expected_bytes.size() != 0)
      report_mismatch("bytes never sent", 32'(expected_bytes.size()), 32'd0);
    if (mismatches == 0) begin
      $display("PASS rtp_h264_fu_a_packetizer_unit");
    end else begin
      $display("FAIL rtp_h264_fu_a_packetizer_unit");
    end
    $finish;
  end

endmodule
